FILE: rtl/spl_pkg.sv
package spl_pkg;

  // Register field widths
  localparam int GAIN_W     = 18;
  localparam int THR_W      = 24;
  localparam int COEF_W     = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 3;

  // Gain fraction bits (Q4.14)
  localparam int GAIN_FRAC = 14;

  // Digit-serial multiplier: multiplier operand width and digit size
  localparam int DIG_W      = 4;
  localparam int MUL_B      = 24;
  localparam int MUL_DIGITS = MUL_B / DIG_W;

  // Divisor width of the limiter (aligned envelope); the same for every sample width
  localparam int DEN_W = 28;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_GAIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_GAIN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE     = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_INPUT_GAIN  = 18'd16384;
  localparam logic [GAIN_W-1:0] RST_OUTPUT_GAIN = 18'd16384;
  localparam logic [THR_W-1:0]  RST_THRESHOLD   = 24'd7919410;
  localparam logic [COEF_W-1:0] RST_ATTACK      = 24'd16617027;
  localparam logic [COEF_W-1:0] RST_RELEASE     = 24'd16773997;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IN_MUL,
    ST_IN_FIN,
    ST_ENV_SET,
    ST_ENV_MUL,
    ST_ENV_FIN,
    ST_LIM_SET,
    ST_LIM_MUL,
    ST_LIM_FIN,
    ST_LIM_DIV,
    ST_OUT_SET,
    ST_OUT_MUL,
    ST_OUT_FIN,
    ST_WRITE
  } spl_state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] in_gain;
    logic [GAIN_W-1:0] out_gain;
    logic [THR_W-1:0]  thresh;
    logic [COEF_W-1:0] atk_coef;
    logic [COEF_W-1:0] rel_coef;
  } spl_cfg_t;

  typedef struct packed {
    spl_state_e st;
    logic       accept;
  } spl_ctrl_t;

endpackage

FILE: rtl/spl_lane.sv
module spl_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spl_pkg::spl_ctrl_t      ctrl_i,
  input  spl_pkg::spl_cfg_t       cfg_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    lim_o,
  output logic [SAMPLE_BITS-1:0]  res_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = SB + 4;
  localparam int FRAC  = SB - 1;
  localparam int SH_DN = (FRAC >= 23) ? FRAC - 23 : 0;
  localparam int SH_UP = (FRAC < 23) ? 23 - FRAC : 0;
  localparam int DIG   = spl_pkg::DIG_W;
  localparam int MB    = spl_pkg::MUL_B;
  localparam int DW    = spl_pkg::DEN_W;
  localparam int PW    = AW + MB;
  localparam int NW    = PW + 1;
  localparam int RW    = PW - (spl_pkg::GAIN_FRAC - 1);
  localparam int TXW   = spl_pkg::THR_W + SH_DN;
  localparam int CMPW  = (AW > TXW) ? AW : TXW;
  localparam int EXW   = AW + SH_UP;
  localparam logic [RW-1:0] GAIN_LIM = RW'(1) << (AW - 1);
  localparam logic [RW-1:0] OUT_LIM  = RW'(1) << (SB - 1);

  logic          neg_q, neg_d;
  logic          ge_q, ge_d;
  logic          lim_q, lim_d;
  logic [AW-1:0] mag_q, mag_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [MB-1:0] lo_q, lo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [AW-1:0] env_q, env_d;

  logic [PW-1:0]     prod;
  logic [AW+DIG-1:0] dig_prod, mul_sum;
  logic [RW:0]       rnd_sum;
  logic [RW-1:0]     rnd, gain_cap, out_cap;
  logic [TXW-1:0]    thr_x;
  logic [EXW-1:0]    env_x, den_x;
  logic [DW-1:0]     den;
  logic [NW-1:0]     dvd;
  logic [DW:0]       div_t, div_diff;
  logic              div_ge;
  logic [SB-1:0]     mag_in;

  assign prod     = {hi_q, lo_q};
  assign dig_prod = (AW+DIG)'(a_q) * (AW+DIG)'(lo_q[DIG-1:0]);
  assign mul_sum  = (AW+DIG)'(hi_q) + dig_prod;

  // Round to nearest, ties away from zero, after the gain fraction shift
  assign rnd_sum  = (RW+1)'(prod[PW-1:spl_pkg::GAIN_FRAC-1]) + (RW+1)'(1);
  assign rnd      = rnd_sum[RW:1];
  assign gain_cap = neg_q ? GAIN_LIM : GAIN_LIM - RW'(1);
  assign out_cap  = neg_q ? OUT_LIM : OUT_LIM - RW'(1);

  // Threshold aligned to the sample fraction, envelope aligned to the threshold's fraction
  assign thr_x = (TXW'(cfg_i.thresh) << SH_DN) >> SH_UP;
  assign lim_o = CMPW'(env_q) > CMPW'(thr_x);
  assign env_x = EXW'(env_q);
  assign den_x = (env_x >> SH_DN) << SH_UP;
  assign den   = den_x[DW-1:0];

  assign dvd      = NW'(prod) + NW'(den[DW-1:1]);
  assign div_t    = {rem_q, hi_q[AW-1]};
  assign div_ge   = div_t >= {1'b0, den};
  assign div_diff = div_t - {1'b0, den};

  assign mag_in = sample_i[SB-1] ? (SB'(0) - sample_i) : sample_i;
  assign res_o  = neg_q ? (SB'(0) - mag_q[SB-1:0]) : mag_q[SB-1:0];

  always_comb begin
    neg_d = neg_q;
    ge_d  = ge_q;
    lim_d = lim_q;
    mag_d = mag_q;
    a_d   = a_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    rem_d = rem_q;
    env_d = env_q;
    case (ctrl_i.st)
      spl_pkg::ST_IDLE: begin
        if (ctrl_i.accept) begin
          neg_d = sample_i[SB-1];
          a_d   = AW'(mag_in);
          hi_d  = '0;
          lo_d  = MB'(cfg_i.in_gain);
        end
      end
      spl_pkg::ST_IN_MUL, spl_pkg::ST_ENV_MUL, spl_pkg::ST_LIM_MUL,
      spl_pkg::ST_OUT_MUL: begin
        // One digit of the multiplier per beat, product shifts right
        hi_d = mul_sum[AW+DIG-1:DIG];
        lo_d = {mul_sum[DIG-1:0], lo_q[MB-1:DIG]};
      end
      spl_pkg::ST_IN_FIN: begin
        mag_d = (rnd > gain_cap) ? gain_cap[AW-1:0] : rnd[AW-1:0];
      end
      spl_pkg::ST_ENV_SET: begin
        ge_d = env_q >= mag_q;
        a_d  = (env_q >= mag_q) ? env_q - mag_q : mag_q - env_q;
        lo_d = (env_q >= mag_q) ? MB'(cfg_i.rel_coef) : MB'(cfg_i.atk_coef);
        hi_d = '0;
      end
      spl_pkg::ST_ENV_FIN: begin
        // hi holds coef * distance >> 24
        env_d = ge_q ? mag_q + hi_q : mag_q - hi_q;
      end
      spl_pkg::ST_LIM_SET: begin
        lim_d = lim_o;
        a_d   = mag_q;
        lo_d  = MB'(cfg_i.thresh);
        hi_d  = '0;
      end
      spl_pkg::ST_LIM_FIN: begin
        // Dividend with half the divisor added for rounding
        rem_d = DW'(dvd[NW-1:AW]);
        hi_d  = dvd[AW-1:0];
      end
      spl_pkg::ST_LIM_DIV: begin
        rem_d = div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
        hi_d  = {hi_q[AW-2:0], div_ge};
      end
      spl_pkg::ST_OUT_SET: begin
        if (lim_q) begin
          a_d = (den == '0) ? '0 : hi_q;
        end else begin
          a_d = mag_q;
        end
        lo_d = MB'(cfg_i.out_gain);
        hi_d = '0;
      end
      spl_pkg::ST_OUT_FIN: begin
        mag_d = (rnd > out_cap) ? AW'(out_cap) : rnd[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else begin
      env_q <= env_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ge_q  <= ge_d;
    lim_q <= lim_d;
    mag_q <= mag_d;
    a_q   <= a_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    rem_q <= rem_d;
  end

endmodule

FILE: rtl/stereo_peak_limiter_unit.sv
// Stereo peak limiter: each accepted beat carries one frame of CHANNELS signed
// samples; every channel gets the input gain (Q4.14, saturating at +/-16), a
// magnitude envelope that rises with the attack and falls with the release
// coefficient, a scale of threshold/envelope whenever the envelope is above the
// threshold, and the output gain with saturation to SAMPLE_BITS. All channels
// run side by side in their own lanes and share one sequencer. Every product
// is formed by a digit-serial multiplier, four bits of the multiplier operand
// per cycle, and the limiting quotient by a restoring divider that yields one
// quotient bit per cycle over SAMPLE_BITS + 4 steps, run only when some
// channel is over the threshold. The result register is loaded in the write
// state, which waits while a previous result is held and not being drained;
// the sequencer then returns to idle. A new frame is taken as soon as the
// sequencer is back at idle, even while the previous result still waits in
// the output register. Envelopes clear on reset; registers may be written
// only while the block is idle.
module stereo_peak_limiter_unit #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Frame in: channel 0 sample in the lowest bits, then channel 1, ... ,
  // zero padding up to a whole byte
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

  // Frame out: channel 0 result in the lowest bits, then channel 1, ... ,
  // zero padding up to a whole byte
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,

  // Register writes
  input  logic                             cfg_we_i,
  input  logic [spl_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [spl_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = SB + 4;
  localparam int CW  = $clog2(AW);
  localparam int TDW = ((CHANNELS*SB+7)/8)*8;

  spl_pkg::spl_state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  spl_pkg::spl_cfg_t   cfg_q, cfg_d;
  spl_pkg::spl_ctrl_t  ctrl;
  logic                m_valid_q, m_valid_d;
  logic [TDW-1:0]      m_data_q, m_data_d;
  logic                m_load;
  logic                mul_last, div_last;
  logic                any_lim;
  logic [CHANNELS-1:0] lane_lim;
  logic [CHANNELS*SB-1:0] res_all;

  assign s_axis_tready = (state_q == spl_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign ctrl.st     = state_q;
  assign ctrl.accept = s_axis_tvalid && s_axis_tready;

  assign mul_last = (cnt_q == CW'(spl_pkg::MUL_DIGITS - 1));
  assign div_last = (cnt_q == CW'(AW - 1));
  assign any_lim  = |lane_lim;

  // One lane per channel, all in step with the sequencer
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    spl_lane #(
      .SAMPLE_BITS(SB)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cfg_i   (cfg_q),
      .sample_i(s_axis_tdata[c*SB +: SB]),
      .lim_o   (lane_lim[c]),
      .res_o   (res_all[c*SB +: SB])
    );
  end

  // Register file: unknown indexes drop the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        spl_pkg::CFG_INPUT_GAIN:  cfg_d.in_gain  = cfg_wdata_i[spl_pkg::GAIN_W-1:0];
        spl_pkg::CFG_OUTPUT_GAIN: cfg_d.out_gain = cfg_wdata_i[spl_pkg::GAIN_W-1:0];
        spl_pkg::CFG_THRESHOLD:   cfg_d.thresh   = cfg_wdata_i[spl_pkg::THR_W-1:0];
        spl_pkg::CFG_ATTACK:      cfg_d.atk_coef = cfg_wdata_i[spl_pkg::COEF_W-1:0];
        spl_pkg::CFG_RELEASE:     cfg_d.rel_coef = cfg_wdata_i[spl_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: gain in, envelope, optional limit, gain out, hand off
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    m_load  = 1'b0;
    case (state_q)
      spl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = spl_pkg::ST_IN_MUL;
        end
      end
      spl_pkg::ST_IN_MUL: begin
        cnt_d = mul_last ? '0 : cnt_q + CW'(1);
        if (mul_last) begin
          state_d = spl_pkg::ST_IN_FIN;
        end
      end
      spl_pkg::ST_IN_FIN:  state_d = spl_pkg::ST_ENV_SET;
      spl_pkg::ST_ENV_SET: state_d = spl_pkg::ST_ENV_MUL;
      spl_pkg::ST_ENV_MUL: begin
        cnt_d = mul_last ? '0 : cnt_q + CW'(1);
        if (mul_last) begin
          state_d = spl_pkg::ST_ENV_FIN;
        end
      end
      spl_pkg::ST_ENV_FIN: state_d = spl_pkg::ST_LIM_SET;
      spl_pkg::ST_LIM_SET: begin
        // Skip the divide when no channel is over the threshold
        state_d = any_lim ? spl_pkg::ST_LIM_MUL : spl_pkg::ST_OUT_SET;
      end
      spl_pkg::ST_LIM_MUL: begin
        cnt_d = mul_last ? '0 : cnt_q + CW'(1);
        if (mul_last) begin
          state_d = spl_pkg::ST_LIM_FIN;
        end
      end
      spl_pkg::ST_LIM_FIN: state_d = spl_pkg::ST_LIM_DIV;
      spl_pkg::ST_LIM_DIV: begin
        cnt_d = div_last ? '0 : cnt_q + CW'(1);
        if (div_last) begin
          state_d = spl_pkg::ST_OUT_SET;
        end
      end
      spl_pkg::ST_OUT_SET: state_d = spl_pkg::ST_OUT_MUL;
      spl_pkg::ST_OUT_MUL: begin
        cnt_d = mul_last ? '0 : cnt_q + CW'(1);
        if (mul_last) begin
          state_d = spl_pkg::ST_OUT_FIN;
        end
      end
      spl_pkg::ST_OUT_FIN: state_d = spl_pkg::ST_WRITE;
      spl_pkg::ST_WRITE: begin
        // Hold until the output register is free or being drained
        if (!m_valid_q || m_axis_tready) begin
          m_load  = 1'b1;
          state_d = spl_pkg::ST_IDLE;
        end
      end
      default: state_d = spl_pkg::ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_load) begin
      m_valid_d = 1'b1;
      m_data_d  = TDW'(res_all);
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= spl_pkg::ST_IDLE;
      cnt_q          <= '0;
      m_valid_q      <= 1'b0;
      cfg_q.in_gain  <= spl_pkg::RST_INPUT_GAIN;
      cfg_q.out_gain <= spl_pkg::RST_OUTPUT_GAIN;
      cfg_q.thresh   <= spl_pkg::RST_THRESHOLD;
      cfg_q.atk_coef <= spl_pkg::RST_ATTACK;
      cfg_q.rel_coef <= spl_pkg::RST_RELEASE;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      cfg_q     <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  // An accepted beat starts the input gain product at its first digit
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=>
      (state_q == spl_pkg::ST_IN_MUL && cnt_q == '0))
    else $error("accepted beat did not start the input gain product");

  // A finished frame never overwrites a result still waiting downstream
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spl_pkg::ST_WRITE && m_valid_q && !m_axis_tready) |=>
      (state_q == spl_pkg::ST_WRITE && m_valid_q && $stable(m_data_q)))
    else $error("result register overwritten while stalled");

  // Outside the divider the step counter stays within one product's digits
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spl_pkg::ST_LIM_DIV) |-> (cnt_q < CW'(spl_pkg::MUL_DIGITS)))
    else $error("digit counter out of range");

endmodule
